>>> hw/rtl/asob_pkg.sv
// Package with the shared types, constants and constant tables of the oscillator bank.
`default_nettype none

package asob_pkg;

    // Bank geometry.
    localparam int N_OSC      = 8;
    localparam int PHASE_BITS = 24;
    localparam int SINE_DEPTH = 1024;   // quarter-wave entries, a power of two

    // Field widths.
    localparam int OP_W      = 2;
    localparam int NOTE_W    = 7;
    localparam int OSC_SEL_W = 3;
    localparam int GAIN_W    = 17;
    localparam int OUT_W     = 20;
    localparam int N_NOTES   = 1 << NOTE_W;

    // Oscillator indexing.
    localparam int OSC_IDX_W = (N_OSC > 1) ? $clog2(N_OSC) : 1;

    // Sine lookup.
    localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
    localparam int SINE_ADDR_W = SINE_IDX_W + 1;
    localparam int SINE_MAG_W  = 17;             // 0 .. 65536
    localparam int SINE_W      = SINE_MAG_W + 1; // signed sine sample

    // Datapath widths of the shared multiplier and the mix accumulator.
    localparam int ACC_W   = SINE_W + GAIN_W + $clog2(N_OSC) + 1;
    localparam int MUL_A_W = ACC_W - 15;
    localparam int MUL_P_W = MUL_A_W + GAIN_W + 1;

    // Configuration port.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

    localparam longint FRAME_RATE  = 48000;
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_WRITE    = 2'd3
    } op_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MASTER_GAIN = 1'b0,
        REG_BANK_GAIN   = 1'b1
    } reg_idx_t;

    // Controls of the shared multiply-accumulate unit.
    typedef struct packed {
        logic prod_load;
        logic acc_clear;
        logic acc_add;
    } mac_ctrl_t;

    typedef logic [SINE_DEPTH:0][SINE_MAG_W-1:0] sine_rom_t;
    typedef logic [N_NOTES-1:0][PHASE_BITS-1:0] note_table_t;
    typedef logic [N_OSC-1:0][PHASE_BITS-1:0]   offset_table_t;
    typedef logic [N_OSC-1:0][GAIN_W-1:0]       gain_table_t;

    // Phase increments of notes 0 to 11 in units of 2^-40 of a full turn per frame.
    function automatic longint note_rom40(input int idx);
        case (idx)
            0:       return 64'd187278874;
            1:       return 64'd198415056;
            2:       return 64'd210213429;
            3:       return 64'd222713370;
            4:       return 64'd235956596;
            5:       return 64'd249987305;
            6:       return 64'd264852324;
            7:       return 64'd280601263;
            8:       return 64'd297286682;
            9:       return 64'd314964268;
            10:      return 64'd333693018;
            default: return 64'd353535438;
        endcase
    endfunction

    // Base increment of every note, rounded half up to the phase width.
    function automatic note_table_t build_note_table();
        note_table_t t;
        longint      inc40;
        int          n;
        for (n = 0; n < N_NOTES; n++) begin
            inc40 = note_rom40(n % 12) << (n / 12);
            t[n]  = PHASE_BITS'((inc40 + (64'sd1 <<< (39 - PHASE_BITS))) >>> (40 - PHASE_BITS));
        end
        return t;
    endfunction

    // Quarter-wave sine in Q1.16, from a Q2.30 Taylor series.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t t;
        longint    x;
        longint    term;
        longint    sum;
        int        k;
        int        n;
        for (k = 0; k <= SINE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * k) / SINE_DEPTH;
            term = x;
            sum  = x;
            for (n = 1; n <= 7; n++) begin
                term = term * x / Q30_ONE;
                term = term * x / Q30_ONE;
                // Each term divides by (2n)(2n+1), truncating toward zero.
                case (n)
                    1:       term = -term / 6;
                    2:       term = -term / 20;
                    3:       term = -term / 42;
                    4:       term = -term / 72;
                    5:       term = -term / 110;
                    6:       term = -term / 156;
                    default: term = -term / 210;
                endcase
                sum  = sum + term;
            end
            sum = (sum + 64'sd8192) >>> 14;
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > 65536) begin
                sum = 65536;
            end
            t[k] = SINE_MAG_W'(sum);
        end
        return t;
    endfunction

    // Offset increments after reset: 55*i Hz at the frame rate.
    function automatic offset_table_t build_offset_reset();
        offset_table_t t;
        int            i;
        for (i = 0; i < N_OSC; i++) begin
            t[i] = PHASE_BITS'(((longint'(55 * i) << PHASE_BITS) + FRAME_RATE / 2) / FRAME_RATE);
        end
        return t;
    endfunction

    // Gains after reset: 1/(i+3) in Q1.16, rounded.
    function automatic gain_table_t build_gain_reset();
        gain_table_t t;
        longint      d;
        longint      num;
        longint      q;
        int          i;
        int          b;
        for (i = 0; i < N_OSC; i++) begin
            d   = longint'(i + 3);
            num = 65536 + (d >>> 1);
            q   = 0;
            // Restoring division, one quotient bit at a time.
            for (b = GAIN_W - 1; b >= 0; b--) begin
                if (((q | (64'sd1 <<< b)) * d) <= num) begin
                    q = q | (64'sd1 <<< b);
                end
            end
            t[i] = GAIN_W'(q);
        end
        return t;
    endfunction

    localparam sine_rom_t     SINE_ROM     = build_sine_rom();
    localparam note_table_t   NOTE_INC     = build_note_table();
    localparam offset_table_t OFFSET_RESET = build_offset_reset();
    localparam gain_table_t   GAIN_RESET   = build_gain_reset();

endpackage

`default_nettype wire

>>> hw/rtl/additive_sine_oscillator_bank.sv
// Top level of the additive sine oscillator bank: sequencer, oscillator state and result register.
//
//   Channel   Ports                                       Transaction
//   input     s_valid/s_ready, s_op .. s_osc_gain         one command: tick, note on/off, write
//   result    m_valid/m_ready, m_left, m_right            one stereo frame per tick
//   config    psel/penable/pwrite/paddr/pwdata/prdata     one 32-bit register write or read
//
// Note on, note off and oscillator writes keep the sequencer idle; s_ready is high again
// on the next cycle. A tick that is not muted holds s_ready low until its frame is loaded
// into the result register, paced by the single shared multiplier: one oscillator per cycle
// through sine ROM, multiply and accumulate, then two more multiplies for bank and master
// gain. A muted tick loads a silent frame. A finished frame waits in the result register
// while the next command is taken; a tick whose frame finds that register still full holds
// until it drains. Reset (aresetn, synchronous, active low) restores the tables and control
// registers at once, but not the datapath registers; there is no initialization pass.
`default_nettype none

module additive_sine_oscillator_bank (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Command channel.
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic        [asob_pkg::OP_W-1:0]       s_op,
    input  wire logic        [asob_pkg::NOTE_W-1:0]     s_note,
    input  wire logic        [asob_pkg::OSC_SEL_W-1:0]  s_osc_index,
    input  wire logic        [asob_pkg::PHASE_BITS-1:0] s_osc_offset,
    input  wire logic        [asob_pkg::GAIN_W-1:0]     s_osc_gain,
    // Frame channel.
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed      [asob_pkg::OUT_W-1:0]      m_left,
    output logic signed      [asob_pkg::OUT_W-1:0]      m_right,
    // Configuration port.
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [asob_pkg::PADDR_W-1:0]    paddr,
    input  wire logic        [asob_pkg::PDATA_W-1:0]    pwdata,
    output logic             [asob_pkg::PDATA_W-1:0]    prdata,
    output logic                                      pready
);
    import asob_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE         = 7'b0000001,
        ST_RUN          = 7'b0000010,
        ST_DRAIN        = 7'b0000100,
        ST_SCALE_BANK   = 7'b0001000,
        ST_SCALE_MASTER = 7'b0010000,
        ST_ROUND        = 7'b0100000,
        ST_OUT          = 7'b1000000
    } state_t;

    localparam logic signed [ACC_W-1:0]   HALF16_A = ACC_W'(1) << 15;
    localparam logic signed [MUL_P_W-1:0] HALF16_P = MUL_P_W'(1) << 15;
    localparam logic signed [MUL_P_W-1:0] HALF17_P = MUL_P_W'(1) << 16;
    localparam logic signed [MUL_P_W-1:0] SAT_HI   = MUL_P_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [MUL_P_W-1:0] SAT_LO   = -SAT_HI - MUL_P_W'(1);
    localparam logic signed [OUT_W-1:0]   OUT_HI   = OUT_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [OUT_W-1:0]   OUT_LO   = -OUT_HI - OUT_W'(1);

    state_t state_reg, state_next;
    logic [OSC_IDX_W-1:0] cnt_reg, cnt_next;

    // Oscillator state.
    logic [PHASE_BITS-1:0] phase_reg  [N_OSC];
    logic [PHASE_BITS-1:0] offset_reg [N_OSC];
    logic [GAIN_W-1:0]     gain_reg   [N_OSC];
    logic [PHASE_BITS-1:0] base_reg, base_next;
    logic                  muted_reg, muted_next;

    // Sine pipeline: ROM read, then multiply, then accumulate.
    logic                  s1_valid_reg;
    logic                  s1_neg_reg;
    logic [GAIN_W-1:0]     s1_gain_reg;
    logic                  s2_valid_reg;

    // Result register.
    logic signed [OUT_W-1:0] res_reg, res_next;
    logic                    m_valid_reg;
    logic signed [OUT_W-1:0] m_data_reg;

    op_t                      in_op;
    logic                     in_fire;
    logic                     osc_wr;
    logic                     phase_adv;
    logic                     out_load;
    logic [OSC_IDX_W-1:0]     wr_idx;
    logic [PHASE_BITS-1:0]    cur_phase;
    logic [SINE_IDX_W+1:0]    sine_idx;
    logic [1:0]               quad;
    logic [SINE_IDX_W-1:0]    quad_pos;
    logic [SINE_ADDR_W-1:0]   rom_addr;
    logic [SINE_MAG_W-1:0]    rom_data;
    logic signed [SINE_W-1:0] sine_val;

    mac_ctrl_t                 mac_ctrl;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [GAIN_W-1:0]         mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [MUL_P_W-1:0] prod_rnd16;
    logic signed [MUL_P_W-1:0] prod_rnd17;
    logic [GAIN_W-1:0]         master_gain;
    logic [GAIN_W-1:0]         bank_gain;

    asob_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .master_gain (master_gain),
        .bank_gain   (bank_gain)
    );

    asob_sine_rom u_sine_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_data)
    );

    asob_mac u_mac (
        .aclk  (aclk),
        .ctrl  (mac_ctrl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod),
        .acc   (acc)
    );

    assign in_op   = op_t'(s_op);
    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign wr_idx  = OSC_IDX_W'(s_osc_index);

    // The phase of the current oscillator selects quadrant and quarter-wave entry.
    // Odd quadrants read the table mirrored; the upper half of the cycle is negated.
    assign cur_phase = phase_reg[cnt_reg];
    assign sine_idx  = cur_phase[PHASE_BITS-1 -: SINE_IDX_W + 2];
    assign quad      = sine_idx[SINE_IDX_W+1:SINE_IDX_W];
    assign quad_pos  = sine_idx[SINE_IDX_W-1:0];
    assign rom_addr  = quad[0] ? (SINE_ADDR_W'(SINE_DEPTH) - {1'b0, quad_pos})
                               : {1'b0, quad_pos};

    assign sine_val = s1_neg_reg ? -signed'({1'b0, rom_data}) : signed'({1'b0, rom_data});

    // Round-half-up steps between the gain stages.
    assign acc_rnd    = (acc + HALF16_A) >>> 16;
    assign prod_rnd16 = (prod + HALF16_P) >>> 16;
    assign prod_rnd17 = (prod + HALF17_P) >>> 17;

    always_comb begin
        state_next          = state_reg;
        cnt_next            = cnt_reg;
        base_next           = base_reg;
        muted_next          = muted_reg;
        res_next            = res_reg;
        osc_wr              = 1'b0;
        phase_adv           = 1'b0;
        out_load            = 1'b0;
        mac_ctrl            = '0;
        mul_a               = MUL_A_W'(sine_val);
        mul_b               = s1_gain_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (in_op)
                        OP_TICK: begin
                            if (muted_reg) begin
                                // A muted frame is silent and leaves every phase alone.
                                res_next   = '0;
                                state_next = ST_OUT;
                            end else begin
                                cnt_next           = '0;
                                mac_ctrl.acc_clear = 1'b1;
                                state_next         = ST_RUN;
                            end
                        end
                        OP_NOTE_ON: begin
                            base_next  = NOTE_INC[s_note];
                            muted_next = 1'b0;
                        end
                        OP_NOTE_OFF: begin
                            muted_next = 1'b1;
                        end
                        OP_WRITE: begin
                            // Writes addressed past the end of the bank are dropped.
                            osc_wr = (int'(s_osc_index) < N_OSC);
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                // An oscillator with zero gain keeps its phase.
                phase_adv = (gain_reg[cnt_reg] != '0);
                if (cnt_reg == OSC_IDX_W'(N_OSC - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + OSC_IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                // The last product is added at the same edge that leaves this state.
                if (!s1_valid_reg) begin
                    state_next = ST_SCALE_BANK;
                end
            end
            ST_SCALE_BANK: begin
                mul_a              = MUL_A_W'(acc_rnd);
                mul_b              = bank_gain;
                mac_ctrl.prod_load = 1'b1;
                state_next         = ST_SCALE_MASTER;
            end
            ST_SCALE_MASTER: begin
                mul_a              = MUL_A_W'(prod_rnd16);
                mul_b              = master_gain;
                mac_ctrl.prod_load = 1'b1;
                state_next         = ST_ROUND;
            end
            ST_ROUND: begin
                if (prod_rnd17 > SAT_HI) begin
                    res_next = OUT_HI;
                end else if (prod_rnd17 < SAT_LO) begin
                    res_next = OUT_LO;
                end else begin
                    res_next = OUT_W'(prod_rnd17);
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (s1_valid_reg) begin
            mac_ctrl.prod_load = 1'b1;
        end
        mac_ctrl.acc_add = s2_valid_reg;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= (state_reg == ST_RUN);
            s2_valid_reg <= s1_valid_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Oscillator tables, base increment and mute flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_OSC; i++) begin
                phase_reg[i]  <= '0;
                offset_reg[i] <= OFFSET_RESET[i];
                gain_reg[i]   <= GAIN_RESET[i];
            end
            base_reg  <= '0;
            muted_reg <= 1'b1;
        end else begin
            base_reg  <= base_next;
            muted_reg <= muted_next;
            if (osc_wr) begin
                offset_reg[wr_idx] <= s_osc_offset;
                gain_reg[wr_idx]   <= s_osc_gain;
            end
            if (phase_adv) begin
                phase_reg[cnt_reg] <= cur_phase + offset_reg[cnt_reg] + base_reg;
            end
        end
    end

    // Pipeline payload and result data.
    always_ff @(posedge aclk) begin
        s1_neg_reg  <= quad[1];
        s1_gain_reg <= gain_reg[cnt_reg];
        res_reg     <= res_next;
        if (out_load) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_left  = m_data_reg;
    assign m_right = m_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/asob_sine_rom.sv
// Quarter-wave sine ROM with a registered read port.
`default_nettype none

module asob_sine_rom (
    input  wire logic                              aclk,
    input  wire logic [asob_pkg::SINE_ADDR_W-1:0]  addr,
    output logic      [asob_pkg::SINE_MAG_W-1:0]   data
);
    import asob_pkg::*;

    logic [SINE_MAG_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/asob_mac.sv
// Shared multiplier with product register and mix accumulator.
`default_nettype none

module asob_mac (
    input  wire logic                                aclk,
    input  wire asob_pkg::mac_ctrl_t                 ctrl,
    input  wire logic signed [asob_pkg::MUL_A_W-1:0] mul_a,
    input  wire logic        [asob_pkg::GAIN_W-1:0]  mul_b,
    output logic signed      [asob_pkg::MUL_P_W-1:0] prod,
    output logic signed      [asob_pkg::ACC_W-1:0]   acc
);
    import asob_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [GAIN_W:0]    mul_b_s;

    assign mul_b_s = signed'({1'b0, mul_b});

    always_ff @(posedge aclk) begin
        if (ctrl.prod_load) begin
            prod_reg <= mul_a * mul_b_s;
        end
        if (ctrl.acc_clear) begin
            acc_reg <= '0;
        end else if (ctrl.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

>>> hw/rtl/asob_apb_regs.sv
// APB configuration registers: master gain and bank gain.
`default_nettype none

module asob_apb_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [asob_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [asob_pkg::PDATA_W-1:0]    pwdata,
    output logic      [asob_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready,
    output logic      [asob_pkg::GAIN_W-1:0]     master_gain,
    output logic      [asob_pkg::GAIN_W-1:0]     bank_gain
);
    import asob_pkg::*;

    logic [GAIN_W-1:0] master_gain_reg;
    logic [GAIN_W-1:0] bank_gain_reg;
    reg_idx_t          reg_idx;
    logic              wr_en;

    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_gain_reg <= GAIN_ONE;
            bank_gain_reg   <= GAIN_ONE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MASTER_GAIN: master_gain_reg <= pwdata[GAIN_W-1:0];
                REG_BANK_GAIN:   bank_gain_reg   <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MASTER_GAIN: prdata = {{(PDATA_W - GAIN_W){1'b0}}, master_gain_reg};
            REG_BANK_GAIN:   prdata = {{(PDATA_W - GAIN_W){1'b0}}, bank_gain_reg};
            default:         prdata = '0;
        endcase
    end

    assign master_gain = master_gain_reg;
    assign bank_gain   = bank_gain_reg;

endmodule

`default_nettype wire

>>> hw/rtl/asob_checker.sv
// Port-level assertions for the oscillator bank and the bind that attaches them.
`default_nettype none

module asob_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic [asob_pkg::OP_W-1:0]       s_op,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic signed [asob_pkg::OUT_W-1:0] m_left,
    input wire logic signed [asob_pkg::OUT_W-1:0] m_right
);
    import asob_pkg::*;

    // Both channels of a frame carry the same sample.
    a_stereo_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left == m_right))
        else $error("left and right samples differ");

    // Commands other than a tick leave s_ready high on the next cycle.
    a_short_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (op_t'(s_op) != OP_TICK)) |=> s_ready)
        else $error("non-tick command did not complete in one cycle");

    // After a tick is taken, s_ready is low on the next cycle.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (op_t'(s_op) == OP_TICK)) |=> !s_ready)
        else $error("command accepted right after a tick");

    // A stalled frame stays put.
    a_frame_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_left)))
        else $error("stalled frame changed or vanished");

endmodule

bind additive_sine_oscillator_bank asob_checker u_asob_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_op    (s_op),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_left  (m_left),
    .m_right (m_right)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench of the additive sine oscillator bank, with its own frame predictor.
`timescale 1ns / 1ps

module tb;
    import asob_pkg::*;

    // The watchdog cuts the whole run off here.
    localparam int CYCLE_LIMIT = 400000;
    // Quiet cycles after the last frame.
    localparam int DRAIN_CYCLES = 40;
    localparam int SEGMENT_ITEMS = 265;

    // One command on the input channel.
    typedef struct {
        op_t                   op;
        logic [NOTE_W-1:0]     note;
        logic [OSC_SEL_W-1:0]  osc_index;
        logic [PHASE_BITS-1:0] osc_offset;
        logic [GAIN_W-1:0]     osc_gain;
    } cmd_t;

    // One row of the directed table. A row that is known carries the frame typed in by hand.
    typedef struct {
        cmd_t                    cmd;
        bit                      known;
        logic signed [OUT_W-1:0] want;
    } row_t;

    // Note increments of the lowest octave in units of 2^-40 of a full turn per frame.
    localparam longint NOTE_INC40 [12] = '{
        187278874, 198415056, 210213429, 222713370,
        235956596, 249987305, 264852324, 280601263,
        297286682, 314964268, 333693018, 353535438
    };

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic        [OP_W-1:0]         s_op;
    logic        [NOTE_W-1:0]       s_note;
    logic        [OSC_SEL_W-1:0]    s_osc_index;
    logic        [PHASE_BITS-1:0]   s_osc_offset;
    logic        [GAIN_W-1:0]       s_osc_gain;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic signed [OUT_W-1:0]        m_left;
    logic signed [OUT_W-1:0]        m_right;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic        [PADDR_W-1:0]      paddr;
    logic        [PDATA_W-1:0]      pwdata;
    logic        [PDATA_W-1:0]      prdata;
    logic                           pready;

    // Predictor state: a private copy of the oscillator tables and the gain registers.
    longint                  quarter_wave [SINE_DEPTH+1];
    logic [PHASE_BITS-1:0]   phase_tab [N_OSC];
    logic [PHASE_BITS-1:0]   offset_tab [N_OSC];
    logic [GAIN_W-1:0]       gain_tab [N_OSC];
    logic [PHASE_BITS-1:0]   base_inc;
    bit                      is_muted;
    logic [GAIN_W-1:0]       master_g;
    logic [GAIN_W-1:0]       bank_g;

    // Frames the bank still owes, oldest first.
    logic signed [OUT_W-1:0] pending_frames [$];
    row_t                    directed_rows [$];

    int                      errors = 0;
    int                      cycles = 0;
    // Percent of cycles in which the sender and the receiver hold off.
    int                      tx_idle = 21;
    int                      rx_idle = 71;

    always #1 aclk = ~aclk;

    additive_sine_oscillator_bank dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_note       (s_note),
        .s_osc_index  (s_osc_index),
        .s_osc_offset (s_osc_offset),
        .s_osc_gain   (s_osc_gain),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_left       (m_left),
        .m_right      (m_right),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch in %s at %0t: got %0d, expected %0d", what, $time, got, want);
        errors++;
    endtask

    // Divide by 2^sh and round half up, also for negative values.
    function automatic longint round_down_shift(input longint v, input int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    // Applies one command to the predicted bank. A tick yields a frame; nothing else does.
    function automatic void step_bank(input cmd_t c, output bit makes_frame,
                                      output logic signed [OUT_W-1:0] frame);
        longint mix;
        longint inc40;
        longint idx;
        longint quad;
        longint k;
        longint sine;
        int     i;
        makes_frame = 1'b0;
        frame = '0;
        case (c.op)
            OP_NOTE_ON: begin
                inc40 = NOTE_INC40[int'(c.note) % 12] << (int'(c.note) / 12);
                base_inc = PHASE_BITS'(round_down_shift(inc40, 40 - PHASE_BITS));
                is_muted = 1'b0;
            end
            OP_NOTE_OFF: begin
                is_muted = 1'b1;
            end
            OP_WRITE: begin
                // All eight indexes that the field can carry lie inside the bank.
                if (int'(c.osc_index) < N_OSC) begin
                    offset_tab[c.osc_index] = c.osc_offset;
                    gain_tab[c.osc_index] = c.osc_gain;
                end
            end
            default: begin
                makes_frame = 1'b1;
                mix = 0;
                if (!is_muted) begin
                    for (i = 0; i < N_OSC; i++) begin
                        // A silent oscillator neither sounds nor moves its phase.
                        if (gain_tab[i] != '0) begin
                            idx = (longint'(phase_tab[i]) * 4 * SINE_DEPTH) >> PHASE_BITS;
                            quad = (idx / SINE_DEPTH) % 4;
                            k = idx % SINE_DEPTH;
                            sine = quad[0] ? quarter_wave[SINE_DEPTH - k] : quarter_wave[k];
                            if (quad[1]) begin
                                sine = -sine;
                            end
                            mix += sine * longint'(gain_tab[i]);
                            phase_tab[i] = phase_tab[i] + offset_tab[i] + base_inc;
                        end
                    end
                    mix = round_down_shift(mix, 16);
                    mix = round_down_shift(mix * longint'(bank_g), 16);
                    mix = round_down_shift(mix * longint'(master_g), 17);
                    if (mix > 524287) begin
                        mix = 524287;
                    end
                    if (mix < -524288) begin
                        mix = -524288;
                    end
                end
                frame = OUT_W'(mix);
            end
        endcase
    endfunction

    // Offers one command, waits for the handshake and books the frame it will cause.
    // Before the offer the sender holds off in about tx_idle cycles of a hundred.
    task automatic send_cmd(input cmd_t c, input bit known, input logic signed [OUT_W-1:0] want);
        bit                      makes_frame;
        logic signed [OUT_W-1:0] frame;
        while (tx_idle != 0 && $urandom_range(0, 99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= c.op;
        s_note <= c.note;
        s_osc_index <= c.osc_index;
        s_osc_offset <= c.osc_offset;
        s_osc_gain <= c.osc_gain;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        step_bank(c, makes_frame, frame);
        if (makes_frame) begin
            if (known) begin
                pending_frames = {pending_frames, want};
            end else begin
                pending_frames = {pending_frames, frame};
            end
        end
    endtask

    task automatic add_row(input op_t op, input int note, input int osc, input int offset,
                           input int gain, input bit known, input int want);
        row_t r;
        r.cmd.op = op;
        r.cmd.note = NOTE_W'(note);
        r.cmd.osc_index = OSC_SEL_W'(osc);
        r.cmd.osc_offset = PHASE_BITS'(offset);
        r.cmd.osc_gain = GAIN_W'(gain);
        r.known = known;
        r.want = OUT_W'(want);
        directed_rows = {directed_rows, r};
    endtask

    // Holds the sender back until every frame owed has arrived and the bank has gone quiet.
    task automatic settle_bank();
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes one gain register and reads it back. Upper data bits carry noise, which the
    // register must drop.
    task automatic apb_write(input reg_idx_t r, input logic [GAIN_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(int'(r) * 4);
        pwdata <= {15'($urandom), v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (r == REG_MASTER_GAIN) begin
            master_g = v;
        end else begin
            bank_g = v;
        end
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== PDATA_W'(v)) begin
            report_mismatch("register read back", longint'(prdata), longint'(v));
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic cmd_t random_command();
        cmd_t c;
        int   r;
        // Mostly ticks, with enough note on traffic that the bank is rarely muted for long.
        r = $urandom_range(0, 99);
        if (r < 70) begin
            c.op = OP_TICK;
        end else if (r < 85) begin
            c.op = OP_WRITE;
        end else if (r < 97) begin
            c.op = OP_NOTE_ON;
        end else begin
            c.op = OP_NOTE_OFF;
        end
        c.note = NOTE_W'($urandom_range(0, 127));
        c.osc_index = OSC_SEL_W'($urandom_range(0, 7));
        c.osc_offset = PHASE_BITS'($urandom_range(0, 24'hFFFFFF));
        r = $urandom_range(0, 9);
        if (r == 0) begin
            c.osc_gain = '0;
        end else if (r == 1) begin
            c.osc_gain = GAIN_ONE;
        end else if (r == 2) begin
            c.osc_gain = '1;
        end else begin
            c.osc_gain = GAIN_W'($urandom_range(0, 131071));
        end
        return c;
    endfunction

    // Quarter-wave sine in Q1.16 from a truncated series in Q2.30, rounded half up.
    initial begin
        longint x;
        longint term;
        longint sum;
        int     k;
        int     n;
        for (k = 0; k <= SINE_DEPTH; k++) begin
            x = (longint'(1686629713) * k) / SINE_DEPTH;
            term = x;
            sum = x;
            for (n = 1; n <= 7; n++) begin
                term = term * x / longint'(1073741824);
                term = term * x / longint'(1073741824);
                term = -term / ((2 * n) * (2 * n + 1));
                sum += term;
            end
            sum = round_down_shift(sum, 14);
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > 65536) begin
                sum = 65536;
            end
            quarter_wave[k] = sum;
        end
    end

    // Receiver: checks every frame against the oldest one owed and stalls at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_frames.size() == 0) begin
                    report_mismatch("unexpected frame, left", longint'(m_left), 0);
                end else begin
                    if (m_left !== pending_frames[0]) begin
                        report_mismatch("left", longint'(m_left), longint'(pending_frames[0]));
                    end
                    if (m_right !== pending_frames[0]) begin
                        report_mismatch("right", longint'(m_right),
                                        longint'(pending_frames[0]));
                    end
                    void'(pending_frames.pop_front());
                end
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        cmd_t             c;
        int               seg;
        int               n;
        int               i;
        logic [GAIN_W-1:0] mg;
        logic [GAIN_W-1:0] bg;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_op <= OP_TICK;
        s_note <= '0;
        s_osc_index <= '0;
        s_osc_offset <= '0;
        s_osc_gain <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;

        // Predicted state after reset: phases at zero, offsets of 55*i Hz, gains of
        // 1/(i+3), no base increment, muted, both gain registers at one.
        for (i = 0; i < N_OSC; i++) begin
            phase_tab[i] = '0;
            offset_tab[i] = PHASE_BITS'(((longint'(55 * i) << PHASE_BITS) + 24000) / 48000);
            gain_tab[i] = GAIN_W'((65536 + (i + 3) / 2) / (i + 3));
        end
        base_inc = '0;
        is_muted = 1'b1;
        master_g = GAIN_ONE;
        bank_g = GAIN_ONE;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The bank wakes up muted, so its first frames are silent; ticks with
        // every field set must not care about those fields.
        add_row(OP_TICK,     0,   0, 0,        0,      1, 0);
        add_row(OP_TICK,     127, 7, 'hFFFFFF, 'h1FFFF, 1, 0);
        add_row(OP_NOTE_OFF, 127, 7, 'hFFFFFF, 'h1FFFF, 0, 0);
        add_row(OP_TICK,     0,   0, 0,        0,      1, 0);
        // Lowest note, with the unused fields of the note on at their maximum.
        add_row(OP_NOTE_ON,  0,   7, 'hFFFFFF, 'h1FFFF, 0, 0);
        // All phases still sit at zero, where the sine is zero.
        add_row(OP_TICK,     0,   0, 0,        0,      1, 0);
        add_row(OP_TICK,     0,   0, 0,        0,      0, 0);
        // Largest offset and a gain above one; then a silent oscillator that must freeze.
        add_row(OP_WRITE,    127, 0, 'hFFFFFF, 'h1FFFF, 0, 0);
        add_row(OP_WRITE,    0,   7, 0,        0,      0, 0);
        add_row(OP_NOTE_ON,  127, 0, 0,        0,      0, 0);
        add_row(OP_TICK,     0,   0, 0,        0,      0, 0);
        add_row(OP_TICK,     0,   0, 0,        0,      0, 0);
        add_row(OP_WRITE,    0,   1, 'h800000, 0,      0, 0);
        add_row(OP_TICK,     0,   0, 0,        0,      0, 0);
        // A muted tick is silent and holds every phase.
        add_row(OP_NOTE_OFF, 0,   0, 0,        0,      0, 0);
        add_row(OP_TICK,     0,   0, 0,        0,      1, 0);
        add_row(OP_TICK,     127, 7, 'hFFFFFF, 'h1FFFF, 1, 0);
        add_row(OP_NOTE_ON,  69,  0, 0,        0,      0, 0);
        add_row(OP_TICK,     0,   0, 0,        0,      0, 0);
        add_row(OP_WRITE,    0,   3, 'h400000, 'h10000, 0, 0);
        add_row(OP_WRITE,    0,   7, 'h000001, 'h00001, 0, 0);
        add_row(OP_NOTE_ON,  60,  0, 0,        0,      0, 0);
        add_row(OP_TICK,     0,   0, 0,        0,      0, 0);
        add_row(OP_TICK,     0,   0, 0,        0,      0, 0);
        for (i = 0; i < directed_rows.size(); i++) begin
            send_cmd(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].want);
        end

        // Random part in segments. Each one starts on a quiet bank with new gain registers:
        // unity, the maximum (the sum saturates), zero in either register, then random.
        // The first two segments have a slow receiver, the next two a slow sender, the
        // last two neither.
        for (seg = 0; seg < 6; seg++) begin
            settle_bank();
            case (seg)
                0: begin
                    mg = GAIN_ONE;
                    bg = GAIN_ONE;
                end
                1: begin
                    mg = '1;
                    bg = '1;
                end
                2: begin
                    mg = '0;
                    bg = GAIN_W'($urandom_range(0, 131071));
                end
                3: begin
                    mg = GAIN_W'($urandom_range(0, 131071));
                    bg = '0;
                end
                default: begin
                    mg = GAIN_W'($urandom_range(0, 131071));
                    bg = GAIN_W'($urandom_range(0, 131071));
                end
            endcase
            apb_write(REG_MASTER_GAIN, mg);
            apb_write(REG_BANK_GAIN, bg);
            if (seg < 2) begin
                tx_idle = 21;
                rx_idle = 71;
            end else if (seg < 4) begin
                tx_idle = 71;
                rx_idle = 21;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                c = random_command();
                send_cmd(c, 1'b0, '0);
            end
        end

        // Let the last frames drain, then leave the bank quiet for a while.
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_frames.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> additive_sine_oscillator_bank.f
hw/rtl/asob_pkg.sv
hw/rtl/asob_sine_rom.sv
hw/rtl/asob_mac.sv
hw/rtl/asob_apb_regs.sv
hw/rtl/additive_sine_oscillator_bank.sv
hw/rtl/asob_checker.sv
tb/sv/tb.sv
